// ===== src/hwj_pkg.sv =====
// Shared types, codes and constants of the window join cell.
package hwj_pkg;

   // Default sizes for the top-level parameters.
   localparam int DefWindowDepth = 16;
   localparam int DefKeyWidth    = 32;

   // Fixed field widths of the item and result channels.
   localparam int WordBits     = 32;
   localparam int ReqDataBits  = 3 * WordBits;
   localparam int RspDataBits  = 3 * WordBits;
   localparam int CsrIndexBits = 2;

   // Configuration register indexes.
   localparam logic [CsrIndexBits-1:0] REG_TIME_BASED    = 2'd0;
   localparam logic [CsrIndexBits-1:0] REG_WINDOW_LENGTH = 2'd1;
   localparam logic [CsrIndexBits-1:0] REG_OFFSET_R      = 2'd2;
   localparam logic [CsrIndexBits-1:0] REG_OFFSET_S      = 2'd3;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_MATCH = 2'd0,
      KIND_LEFT  = 2'd1,
      KIND_RIGHT = 2'd2
   } hwj_kind_type;

   // One result item.
   typedef struct packed {
      hwj_kind_type        kind;
      logic [WordBits-1:0] key;
      logic [WordBits-1:0] stamp;
      logic [WordBits-1:0] total;
   } hwj_result_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic pop_opp;
      logic probe;
      logic tally;
      logic push;
      logic pop_own;
      logic finish;
   } hwj_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic opp_hit;
      logic own_hit;
      logic own_full;
      logic can_emit;
      logic out_free;
   } hwj_stat_type;

   // Commands and status of one window store.
   typedef struct packed {
      logic pop;
      logic push;
   } hwj_win_cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } hwj_win_stat_type;

endpackage

// ===== src/hwj_win.sv =====
// One FIFO-ordered tuple window with parallel key comparators.
module hwj_win
   import hwj_pkg::*;
#(
   parameter int DEPTH     = DefWindowDepth,
   parameter int KEY_WIDTH = DefKeyWidth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hwj_win_cmd_type       cmd,
   input  logic [WordBits-1:0]   push_key,
   input  logic [WordBits-1:0]   push_stamp,
   input  logic [WordBits-1:0]   probe_key,
   output logic [WordBits-1:0]   head_key,
   output logic [WordBits-1:0]   head_stamp,
   output hwj_win_stat_type      stat,
   output logic [DEPTH-1:0]      match_vec
);

   localparam int HeadW = $clog2(DEPTH);
   localparam int FillW = $clog2(DEPTH + 1);
   localparam int SumW  = FillW + 1;
   localparam int CmpW  = (KEY_WIDTH < WordBits) ? KEY_WIDTH : WordBits;

   logic [WordBits-1:0] keys_ff   [DEPTH];
   logic [WordBits-1:0] stamps_ff [DEPTH];
   logic [HeadW-1:0]    head_ff, head_in, head_next;
   logic [FillW-1:0]    fill_ff, fill_in;
   logic [SumW-1:0]     tail_sum, tail_wrap;
   logic [HeadW-1:0]    wr_addr;
   logic                full;

   assign full       = (fill_ff == FillW'(DEPTH));
   assign stat.full  = full;
   assign stat.empty = (fill_ff == '0);
   assign head_key   = keys_ff[head_ff];
   assign head_stamp = stamps_ff[head_ff];

   // Next head position, wrapping at the depth.
   assign head_next = (head_ff == HeadW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Tail slot: head plus fill stays below twice the depth.
   assign tail_sum  = SumW'(head_ff) + SumW'(fill_ff);
   assign tail_wrap = (tail_sum >= SumW'(DEPTH)) ? tail_sum - SumW'(DEPTH) : tail_sum;
   // A full window overwrites its oldest entry, which is evicted at the same time.
   assign wr_addr   = full ? head_ff : tail_wrap[HeadW-1:0];

   // Head and fill update.
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         head_in = head_next;
         fill_in = fill_ff - 1'b1;
      end else if (cmd.push) begin
         if (full) begin
            head_in = head_next;
         end else begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         keys_ff[wr_addr]   <= push_key;
         stamps_ff[wr_addr] <= push_stamp;
      end
   end

   // One comparator per entry, masked by whether the entry is live.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
      logic [SumW-1:0] age;
      logic            live;
      assign age  = (SumW'(i) >= SumW'(head_ff)) ? SumW'(i) - SumW'(head_ff)
                                                 : SumW'(i) + SumW'(DEPTH) - SumW'(head_ff);
      assign live = (age < SumW'(fill_ff));
      assign match_vec[i] = live && (keys_ff[i][CmpW-1:0] == probe_key[CmpW-1:0]);
   end

endmodule

// ===== src/hwj_ctrl.sv =====
// Sequencing state machine of the window join cell.
module hwj_ctrl
   import hwj_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  hwj_stat_type stat,
   output hwj_cmd_type  cmd
);

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_EXP_OPP = 7'b0000010,
      ST_PROBE   = 7'b0000100,
      ST_TALLY   = 7'b0001000,
      ST_PUSH    = 7'b0010000,
      ST_EXP_OWN = 7'b0100000,
      ST_FINISH  = 7'b1000000
   } hwj_state_type;

   hwj_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Step through expire, probe, count, push, expire, report.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_EXP_OPP;
            end
         end
         ST_EXP_OPP: begin
            if (stat.opp_hit) begin
               cmd.pop_opp = stat.can_emit;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            cmd.probe = 1'b1;
            state_in  = ST_TALLY;
         end
         ST_TALLY: begin
            cmd.tally = 1'b1;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            // A push into a full window evicts an item, which needs room.
            if (!stat.own_full || stat.can_emit) begin
               cmd.push = 1'b1;
               state_in = ST_EXP_OWN;
            end
         end
         ST_EXP_OWN: begin
            if (stat.own_hit) begin
               cmd.pop_own = stat.can_emit;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/hwj_datapath.sv =====
// Datapath: item and configuration registers, windows, counters and result staging.
module hwj_datapath
   import hwj_pkg::*;
#(
   parameter int WINDOW_DEPTH = DefWindowDepth,
   parameter int KEY_WIDTH    = DefKeyWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hwj_cmd_type             cmd,
   output hwj_stat_type            stat,
   input  logic [ReqDataBits-1:0]  req_tdata,
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataBits-1:0]  rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [WordBits-1:0]     csr_wdata
);

   localparam int CntW = $clog2(WINDOW_DEPTH + 1);
   localparam int LimW = WordBits + 1;

   // Configuration registers.
   logic                time_ff;
   logic [WordBits-1:0] wlen_ff, off_r_ff, off_s_ff;

   // Current item.
   logic                is_s_ff;
   logic [WordBits-1:0] key_ff, stamp_ff, now_ff;

   // Counters.
   logic [WordBits-1:0] r_ctr_ff, s_ctr_ff, match_ff;
   logic [WordBits-1:0] r_ctr_in, s_ctr_in, match_in;

   logic [WINDOW_DEPTH-1:0] match_vec_ff;

   // Result staging: one held result, then the output register.
   hwj_result_type hold_ff, out_ff, new_res;
   logic           hold_v_ff, hold_v_in, out_v_ff, out_v_in, out_last_ff;

   // Window interfaces.
   hwj_win_cmd_type         r_cmd, s_cmd;
   hwj_win_stat_type        r_stat, s_stat;
   logic [WordBits-1:0]     r_head_key, r_head_stamp, s_head_key, s_head_stamp;
   logic [WINDOW_DEPTH-1:0] r_match, s_match;

   logic [WordBits-1:0] opp_head_key, opp_head_stamp, own_head_key, own_head_stamp;
   logic [WordBits-1:0] own_ctr, own_ref, opp_dist, own_dist;
   logic [LimW-1:0]     limit_r, limit_s, opp_limit, own_limit;
   logic                opp_empty, own_empty, own_full, emit, out_free;
   logic [CntW-1:0]     match_cnt;

   // Window commands: the own window is R for an R item, S for an S item.
   assign r_cmd.pop  = (cmd.pop_opp && is_s_ff) || (cmd.pop_own && !is_s_ff);
   assign r_cmd.push = cmd.push && !is_s_ff;
   assign s_cmd.pop  = (cmd.pop_opp && !is_s_ff) || (cmd.pop_own && is_s_ff);
   assign s_cmd.push = cmd.push && is_s_ff;

   hwj_win #(.DEPTH(WINDOW_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_win_r (
      .clock      (clock),
      .reset      (reset),
      .cmd        (r_cmd),
      .push_key   (key_ff),
      .push_stamp (stamp_ff),
      .probe_key  (key_ff),
      .head_key   (r_head_key),
      .head_stamp (r_head_stamp),
      .stat       (r_stat),
      .match_vec  (r_match)
   );

   hwj_win #(.DEPTH(WINDOW_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_win_s (
      .clock      (clock),
      .reset      (reset),
      .cmd        (s_cmd),
      .push_key   (key_ff),
      .push_stamp (stamp_ff),
      .probe_key  (key_ff),
      .head_key   (s_head_key),
      .head_stamp (s_head_stamp),
      .stat       (s_stat),
      .match_vec  (s_match)
   );

   // Own and opposite views of the two windows.
   assign opp_head_key   = is_s_ff ? r_head_key   : s_head_key;
   assign opp_head_stamp = is_s_ff ? r_head_stamp : s_head_stamp;
   assign own_head_key   = is_s_ff ? s_head_key   : r_head_key;
   assign own_head_stamp = is_s_ff ? s_head_stamp : r_head_stamp;
   assign opp_empty      = is_s_ff ? r_stat.empty : s_stat.empty;
   assign own_empty      = is_s_ff ? s_stat.empty : r_stat.empty;
   assign own_full       = is_s_ff ? s_stat.full  : r_stat.full;
   assign own_ctr        = is_s_ff ? s_ctr_ff     : r_ctr_ff;

   // Expiry limits are formed one bit wider so they never wrap.
   assign limit_r   = LimW'(wlen_ff) + LimW'(off_r_ff);
   assign limit_s   = LimW'(wlen_ff) + LimW'(off_s_ff);
   assign opp_limit = is_s_ff ? limit_r : limit_s;
   assign own_limit = is_s_ff ? limit_s : limit_r;

   // Head distances, modulo two to the word width.
   assign own_ref  = time_ff ? now_ff : own_ctr;
   assign opp_dist = now_ff - opp_head_stamp;
   assign own_dist = own_ref - own_head_stamp;

   assign out_free      = !out_v_ff || rsp_tready;
   assign stat.opp_hit  = time_ff && !opp_empty && (LimW'(opp_dist) > opp_limit);
   assign stat.own_hit  = !own_empty && (LimW'(own_dist) > own_limit);
   assign stat.own_full = own_full;
   assign stat.out_free = out_free;
   assign stat.can_emit = !hold_v_ff || out_free;

   // A forwarded item comes from an expiry pop or a full-window eviction.
   assign emit = cmd.pop_opp || cmd.pop_own || (cmd.push && own_full);

   always_comb begin
      new_res.total = match_ff;
      if (cmd.pop_opp) begin
         new_res.kind  = is_s_ff ? KIND_LEFT : KIND_RIGHT;
         new_res.key   = opp_head_key;
         new_res.stamp = opp_head_stamp;
      end else begin
         new_res.kind  = is_s_ff ? KIND_RIGHT : KIND_LEFT;
         new_res.key   = own_head_key;
         new_res.stamp = own_head_stamp;
      end
   end

   assign match_cnt = CntW'($countones(match_vec_ff));

   // Match total and arrival counters.
   always_comb begin
      match_in = match_ff;
      r_ctr_in = r_ctr_ff;
      s_ctr_in = s_ctr_ff;
      if (cmd.tally) begin
         match_in = match_ff + WordBits'(match_cnt);
         if (!time_ff) begin
            if (is_s_ff) begin
               s_ctr_in = s_ctr_ff + 1'b1;
            end else begin
               r_ctr_in = r_ctr_ff + 1'b1;
            end
         end
      end
   end

   // Staging valid flags.
   always_comb begin
      hold_v_in = hold_v_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      if (emit) begin
         hold_v_in = 1'b1;
         if (hold_v_ff) begin
            out_v_in = 1'b1;
         end
      end
      if (cmd.finish) begin
         hold_v_in = 1'b0;
         out_v_in  = 1'b1;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff   <= 1'b0;
         wlen_ff   <= WordBits'(8);
         off_r_ff  <= '0;
         off_s_ff  <= '0;
         r_ctr_ff  <= '0;
         s_ctr_ff  <= '0;
         match_ff  <= '0;
         hold_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         r_ctr_ff  <= r_ctr_in;
         s_ctr_ff  <= s_ctr_in;
         match_ff  <= match_in;
         hold_v_ff <= hold_v_in;
         out_v_ff  <= out_v_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_TIME_BASED:    time_ff  <= csr_wdata[0];
               REG_WINDOW_LENGTH: wlen_ff  <= csr_wdata;
               REG_OFFSET_R:      off_r_ff <= csr_wdata;
               REG_OFFSET_S:      off_s_ff <= csr_wdata;
            endcase
         end
      end
   end

   // Item capture, probe result and count-mode stamping.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_s_ff  <= req_tuser;
         key_ff   <= req_tdata[WordBits-1:0];
         stamp_ff <= req_tdata[2*WordBits-1:WordBits];
         now_ff   <= req_tdata[3*WordBits-1:2*WordBits];
      end else if (cmd.tally && !time_ff) begin
         stamp_ff <= own_ctr;
      end
      if (cmd.probe) begin
         match_vec_ff <= is_s_ff ? r_match : s_match;
      end
   end

   // Result payload: a new item pushes the held one out as not final.
   always_ff @(posedge clock) begin
      if (emit) begin
         hold_ff <= new_res;
         if (hold_v_ff) begin
            out_ff      <= hold_ff;
            out_last_ff <= 1'b0;
         end
      end
      if (cmd.finish) begin
         out_last_ff <= 1'b1;
         if (hold_v_ff) begin
            out_ff <= hold_ff;
         end else begin
            out_ff.kind  <= KIND_MATCH;
            out_ff.key   <= '0;
            out_ff.stamp <= '0;
            out_ff.total <= match_ff;
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.total, out_ff.stamp, out_ff.key};
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== src/handshake_window_join_cell.sv =====
// Top level of the sliding-window stream join cell.
//
// Items enter on the req_ channel: an R or S tuple with its key, stamp and the
// current time. Each item probes the opposite window, bumps the wrapping match
// total and is appended to its own window; window heads that fall out of range
// are forwarded on the rsp_ channel (R to the left, S to the right). An item
// that forwards nothing yields one match report; tlast marks its final result.
// The user writes configuration via csr_ port only while idle (not enforced).
//
// Sequence: an item passes the sequencer states idle, opposite expiry, probe,
// tally, push, own expiry and finish; a full-window eviction rides on the push
// cycle. The window probe uses one comparator per entry, and expiry pops one
// head per cycle while the result staging has room. A match report enters the
// output register in the finish state. A forwarded tuple is held back until the
// next result of its item appears or the item ends, so that tlast can be set.
// A new item is taken while the previous final result still waits on rsp_.
//
// Reset empties both windows, clears the arrival counters and the match total
// and restores the default configuration. A stalled receiver holds the output
// register, and the sequencer waits whenever a further result has nowhere to go.
module handshake_window_join_cell
   import hwj_pkg::*;
#(
   parameter int WINDOW_DEPTH = DefWindowDepth,
   parameter int KEY_WIDTH    = DefKeyWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // tuple_key, tuple_stamp, now_time
   input  logic [ReqDataBits-1:0]  req_tdata,
   // req_type
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // out_key, out_stamp, match_total
   output logic [RspDataBits-1:0]  rsp_tdata,
   // result_kind
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast,
   input  logic                    csr_we,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [WordBits-1:0]     csr_wdata
);

   hwj_cmd_type  cmd;
   hwj_stat_type stat;

   hwj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hwj_datapath #(.WINDOW_DEPTH(WINDOW_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

// ===== src/hwj_checker.sv =====
// Port-level checks of the window join cell and their binding.
module hwj_checker
   import hwj_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [RspDataBits-1:0]  rsp_tdata,
   input logic [1:0]              rsp_tuser,
   input logic                    rsp_tlast
);

   // Items taken whose final result has not yet been delivered.
   logic [1:0] pending_ff;
   logic       req_acc, last_acc;

   assign req_acc  = req_tvalid && req_tready;
   assign last_acc = rsp_tvalid && rsp_tready && rsp_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + {1'b0, req_acc} - {1'b0, last_acc};
      end
   end

   // A stalled result holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // A match report is always final and carries no tuple.
   a_report_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_MATCH) |-> rsp_tlast
                                                 && (rsp_tdata[2*WordBits-1:0] == '0))
      else $error("malformed match report");

   // No result without an item behind it.
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pending_ff != 2'd0))
      else $error("result without an outstanding item");

   // A new item is taken only once earlier items are done but for their final result.
   a_one_ahead: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> (pending_ff == 2'd0) || (pending_ff == 2'd1 && rsp_tvalid && rsp_tlast))
      else $error("item taken while another is still in work");

endmodule

bind handshake_window_join_cell hwj_checker u_hwj_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== tb/sv/tb_handshake_window_join_cell.sv =====
// Self-checking testbench of the sliding-window stream join cell.
module tb_handshake_window_join_cell;
   import hwj_pkg::*;

   localparam int Depth        = DefWindowDepth;
   localparam int SettleCycles = 12;
   localparam int DrainCycles  = 24;
   localparam int StallLimit   = 3000;
   localparam int LongHold     = 300;
   localparam int Phases       = 8;
   localparam int PhaseItems   = 30;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   // One tuple as it enters the cell.
   typedef struct {
      logic        is_s;
      logic [31:0] key;
      logic [31:0] stamp;
      logic [31:0] now;
   } tuple_item_type;

   // One result item including its end-of-item mark.
   typedef struct {
      hwj_kind_type kind;
      logic [31:0]  key;
      logic [31:0]  stamp;
      logic [31:0]  total;
      logic         last;
   } join_result_type;

   // One row of the directed stimulus table.
   typedef struct {
      row_op_type                op;
      tuple_item_type            item;
      logic [CsrIndexBits-1:0]   csr_idx;
      logic [31:0]               csr_val;
      bit                        typed;
      logic [31:0]               typed_total;
   } stim_row_type;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataBits-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataBits-1:0]  rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_we;
   logic [CsrIndexBits-1:0] csr_index;
   logic [WordBits-1:0]     csr_wdata;

   // Shadow copy of the cell: windows, counters and configuration.
   logic [31:0]     win_key [2][Depth];
   logic [31:0]     win_stamp [2][Depth];
   int unsigned     win_head [2];
   int unsigned     win_fill [2];
   logic [31:0]     arrivals [2];
   logic [31:0]     match_total;
   logic            cfg_time_based;
   logic [31:0]     cfg_length;
   logic [31:0]     cfg_offset [2];

   join_result_type item_results[$];
   join_result_type awaited_results[$];
   stim_row_type    directed_rows[$];
   int              errors;
   bit              hold_request;
   bit              hold_done;

   handshake_window_join_cell dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Forward the head of one window as an R or S result.
   function automatic void forward_head(int side);
      join_result_type r;
      r.kind  = side ? KIND_RIGHT : KIND_LEFT;
      r.key   = win_key[side][win_head[side]];
      r.stamp = win_stamp[side][win_head[side]];
      r.total = match_total;
      r.last  = 1'b0;
      item_results.push_back(r);
      win_head[side] = (win_head[side] + 1) % Depth;
      win_fill[side]--;
   endfunction

   // Pop heads whose distance from the reference point exceeds the limit.
   function automatic void expire_side(int side, logic [31:0] ref_point);
      logic [32:0] limit;
      logic [31:0] head_dist;
      limit = {1'b0, cfg_length} + {1'b0, cfg_offset[side]};
      while (win_fill[side] > 0) begin
         head_dist = ref_point - win_stamp[side][win_head[side]];
         if ({1'b0, head_dist} <= limit) break;
         forward_head(side);
      end
   endfunction

   // Count key matches against every entry of one window.
   function automatic void probe_side(int side, logic [31:0] key);
      int unsigned idx;
      for (int unsigned i = 0; i < win_fill[side]; i++) begin
         idx = (win_head[side] + i) % Depth;
         if (win_key[side][idx] == key) match_total = match_total + 32'd1;
      end
   endfunction

   // Append a tuple, evicting the oldest entry of a full window first.
   function automatic void push_side(int side, logic [31:0] key, logic [31:0] stamp);
      int unsigned idx;
      if (win_fill[side] >= Depth) forward_head(side);
      idx = (win_head[side] + win_fill[side]) % Depth;
      win_key[side][idx]   = key;
      win_stamp[side][idx] = stamp;
      win_fill[side]++;
   endfunction

   // Work out every result that one accepted tuple causes.
   function automatic void step_join_cell(tuple_item_type it);
      int              own;
      int              opp;
      logic [31:0]     stamp;
      join_result_type r;
      own = it.is_s ? 1 : 0;
      opp = 1 - own;
      item_results.delete();
      if (cfg_time_based) begin
         expire_side(opp, it.now);
         probe_side(opp, it.key);
         push_side(own, it.key, it.stamp);
         expire_side(own, it.now);
      end else begin
         stamp = arrivals[own];
         probe_side(opp, it.key);
         arrivals[own] = stamp + 32'd1;
         push_side(own, it.key, stamp);
         expire_side(own, arrivals[own]);
      end
      if (item_results.size() == 0) begin
         r.kind  = KIND_MATCH;
         r.key   = '0;
         r.stamp = '0;
         r.total = match_total;
         r.last  = 1'b0;
         item_results.push_back(r);
      end
      item_results[item_results.size() - 1].last = 1'b1;
   endfunction

   function automatic void add_item(logic is_s, logic [31:0] key, logic [31:0] stamp,
                                    logic [31:0] now, bit typed, logic [31:0] total);
      stim_row_type row;
      row.op          = ROW_ITEM;
      row.item.is_s   = is_s;
      row.item.key    = key;
      row.item.stamp  = stamp;
      row.item.now    = now;
      row.csr_idx     = REG_TIME_BASED;
      row.csr_val     = '0;
      row.typed       = typed;
      row.typed_total = total;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [CsrIndexBits-1:0] idx, logic [31:0] val);
      stim_row_type row;
      row.op          = ROW_CSR;
      row.item        = '{1'b0, 32'd0, 32'd0, 32'd0};
      row.csr_idx     = idx;
      row.csr_val     = val;
      row.typed       = 1'b0;
      row.typed_total = '0;
      directed_rows.push_back(row);
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: result %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   // Offer one tuple after a gap and predict its results once it is taken.
   task automatic offer_item(tuple_item_type it, int gap, bit typed, logic [31:0] total);
      join_result_type r;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.now, it.stamp, it.key};
      req_tuser  <= it.is_s;
      do @(posedge clock); while (!req_tready);
      step_join_cell(it);
      if (typed) begin
         r.kind  = KIND_MATCH;
         r.key   = '0;
         r.stamp = '0;
         r.total = total;
         r.last  = 1'b1;
         awaited_results.push_back(r);
      end else begin
         foreach (item_results[i]) awaited_results.push_back(item_results[i]);
      end
   endtask

   // Stop offering and wait until the cell has delivered everything and settled.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_register(logic [CsrIndexBits-1:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_TIME_BASED:    cfg_time_based = val[0];
         REG_WINDOW_LENGTH: cfg_length = val;
         REG_OFFSET_R:      cfg_offset[0] = val;
         REG_OFFSET_S:      cfg_offset[1] = val;
         default: ;
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Result sink: checks each item and stalls at random.
   initial begin : result_sink
      int              stall_left;
      int              mode_left;
      bit              choppy;
      join_result_type want;
      stall_left = 0;
      mode_left  = 0;
      choppy     = 1'b0;
      hold_done  = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               if (awaited_results.size() == 0) begin
                  $display("%0t: unexpected result, kind %0d key %h stamp %h total %h last %b",
                           $time, rsp_tuser, rsp_tdata[31:0], rsp_tdata[63:32],
                           rsp_tdata[95:64], rsp_tlast);
                  errors++;
               end else begin
                  want = awaited_results.pop_front();
                  check_field("kind", 32'(want.kind), 32'(rsp_tuser));
                  check_field("key", want.key, rsp_tdata[31:0]);
                  check_field("stamp", want.stamp, rsp_tdata[63:32]);
                  check_field("total", want.total, rsp_tdata[95:64]);
                  check_field("last", 32'(want.last), 32'(rsp_tlast));
               end
               // Switch between smooth and choppy stretches now and then.
               if (mode_left == 0) begin
                  choppy    = 1'($urandom_range(0, 1));
                  mode_left = $urandom_range(10, 40);
               end else begin
                  mode_left--;
               end
               stall_left = choppy ? $urandom_range(0, 5) : 0;
            end
            // One long hold-off so the cell fills up and stalls its input.
            if (hold_request && !hold_done) begin
               stall_left = LongHold;
               hold_done  = 1'b1;
            end
            rsp_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
         end
      end
   end

   // Watchdog on cycles in which no item moves anywhere.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet = 0;
         else
            quiet++;
         if (quiet >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, quiet);
            $display("handshake_window_join_cell test failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      tuple_item_type it;
      logic [31:0]    key_pool [4];
      logic [31:0]    stream_time;
      int             s_weight;
      bit             gappy;
      logic [31:0]    val;

      errors         = 0;
      hold_request   = 1'b0;
      win_head       = '{0, 0};
      win_fill       = '{0, 0};
      arrivals       = '{32'd0, 32'd0};
      match_total    = '0;
      cfg_time_based = 1'b0;
      cfg_length     = 32'd8;
      cfg_offset     = '{32'd0, 32'd0};

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= REG_TIME_BASED;
      csr_wdata  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Count mode straight after reset: match reports with known totals.
      add_item(1'b0, 32'h0, 32'h0, 32'h0, 1'b1, 32'd0);
      add_item(1'b1, 32'h0, 32'h0, 32'h0, 1'b1, 32'd1);
      add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd1);
      add_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd2);
      // Enough R tuples for the oldest to run out of the default window.
      for (int i = 0; i < 7; i++)
         add_item(1'b0, 32'h1 << (i * 5), $urandom, $urandom, 1'b0, '0);
      // Time mode with a zero window; the upper bits of the mode word are ignored.
      add_csr(REG_TIME_BASED, 32'hFFFF_FFFF);
      add_csr(REG_WINDOW_LENGTH, 32'h0);
      add_csr(REG_OFFSET_R, 32'h0);
      add_csr(REG_OFFSET_S, 32'h0);
      add_item(1'b1, 32'h1, 32'd100, 32'd100, 1'b0, '0);
      add_item(1'b0, 32'h1, 32'd100, 32'd100, 1'b0, '0);
      add_item(1'b0, 32'h1, 32'hFFFF_FFF0, 32'd5, 1'b0, '0);
      // An R offset lets an entry sit right on the limit.
      add_csr(REG_OFFSET_R, 32'd3);
      add_item(1'b0, 32'h1, 32'd2, 32'd5, 1'b0, '0);
      add_item(1'b0, 32'h2, 32'd1, 32'd5, 1'b0, '0);
      // Largest limits: nothing can ever expire.
      add_csr(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
      add_csr(REG_OFFSET_R, 32'hFFFF_FFFF);
      add_csr(REG_OFFSET_S, 32'hFFFF_FFFF);
      add_item(1'b1, 32'h1, 32'h0, 32'hFFFF_FFFF, 1'b0, '0);
      add_item(1'b0, 32'h2, 32'hFFFF_FFFF, 32'h0, 1'b0, '0);
      // Back to count mode with a zero window: each tuple expires at once.
      add_csr(REG_TIME_BASED, 32'hFFFF_FFFE);
      add_csr(REG_WINDOW_LENGTH, 32'h0);
      add_csr(REG_OFFSET_R, 32'h0);
      add_csr(REG_OFFSET_S, 32'h0);
      add_item(1'b0, 32'h2, 32'h0, 32'h0, 1'b0, '0);
      add_item(1'b1, 32'h2, 32'h0, 32'h0, 1'b0, '0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == ROW_CSR) begin
            if (i == 0 || directed_rows[i-1].op != ROW_CSR) drain_results();
            write_register(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            offer_item(directed_rows[i].item, $urandom_range(0, 5),
                       directed_rows[i].typed, directed_rows[i].typed_total);
         end
      end

      // Random phases, each under a fresh configuration written while idle.
      for (int p = 0; p < Phases; p++) begin
         drain_results();
         val = $urandom;
         val[0] = (p == 0) ? 1'b0 : 1'($urandom_range(0, 1));
         write_register(REG_TIME_BASED, val);
         case ($urandom_range(0, 5))
            0:       val = 32'h0;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom_range(1, 24);
         endcase
         if (p == 0) val = 32'hFFFF_FFFF;
         write_register(REG_WINDOW_LENGTH, val);
         for (int side = 0; side < 2; side++) begin
            case ($urandom_range(0, 4))
               0:       val = 32'h0;
               1:       val = 32'hFFFF_FFFF;
               default: val = $urandom_range(0, 8);
            endcase
            write_register(side ? REG_OFFSET_S : REG_OFFSET_R, val);
         end

         key_pool[0] = $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
         for (int k = 1; k < 4; k++) key_pool[k] = $urandom;
         stream_time = $urandom;
         s_weight    = (p == 0) ? 2 : $urandom_range(1, 9);
         gappy       = $urandom_range(0, 2) != 0;

         for (int n = 0; n < PhaseItems; n++) begin
            if (p == 3 && n == 4) hold_request = 1'b1;
            it.is_s = $urandom_range(0, 9) < s_weight;
            it.key  = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, 3)];
            // Mostly advancing time with recent stamps; some noise.
            if ($urandom_range(0, 9) == 0) begin
               it.stamp = $urandom;
               it.now   = $urandom;
            end else begin
               stream_time = stream_time + $urandom_range(0, 3);
               it.now      = stream_time;
               it.stamp    = stream_time - $urandom_range(0, 4);
            end
            offer_item(it, gappy ? $urandom_range(0, 5) : 0, 1'b0, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0)
         $display("handshake_window_join_cell test passed");
      else
         $display("handshake_window_join_cell test failed");
      $finish;
   end

endmodule
